[design/leaky_integrate_fire_spike_encoder_defines.svh]
// Assertion macros shared by the spike encoder RTL.
`ifndef LEAKY_INTEGRATE_FIRE_SPIKE_ENCODER_DEFINES_SVH
`define LEAKY_INTEGRATE_FIRE_SPIKE_ENCODER_DEFINES_SVH

`ifndef ASSERT_OFF
`define LIF_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LIF_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define LIF_ASSERT_IMPLY(label, ante, cons, msg)
`define LIF_ASSERT_NEVER(label, cond, msg)
`endif

`endif

[design/lif_pkg.sv]
`default_nettype none

package lif_pkg;

    localparam int NUM_CHANNELS = 64;
    localparam int CH_W         = 6;
    localparam int IDX_W        = $clog2(NUM_CHANNELS);
    localparam int TIME_W       = 48;
    localparam int SMP_W        = 16;
    localparam int RND_W        = 32;
    localparam int THR_W        = 48;
    localparam int ACC_W        = 48;
    localparam int LEAK_W       = 17;
    localparam int WGT_W        = 16;
    localparam int TICKS_W      = 24;
    localparam int WSMP_W       = SMP_W + WGT_W;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;
    localparam int QUEUE_DEPTH  = 4;
    localparam int LEAK_FRAC    = 16;

    localparam logic [LEAK_W-1:0] LEAK_ONE = LEAK_W'(1 << LEAK_FRAC);
    localparam logic [WGT_W-1:0]  WEIGHT_RESET = WGT_W'(1);

    typedef enum logic
    {
        CMD_SAMPLE = 1'b0,
        CMD_LOAD   = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_LEAK_FACTOR      = 2'd0,
        REG_SAMPLE_WEIGHT    = 2'd1,
        REG_REFRACTORY_TICKS = 2'd2
    } reg_index_t;

    typedef struct packed
    {
        logic [LEAK_W-1:0]  leak_factor;
        logic [WGT_W-1:0]   sample_weight;
        logic [TICKS_W-1:0] refractory_ticks;
    } cfg_t;

    typedef struct packed
    {
        cmd_t                      command;
        logic [CH_W-1:0]           channel;
        logic [TIME_W-1:0]         sample_time;
        logic signed [SMP_W-1:0]   sample;
        logic signed [WSMP_W-1:0]  weighted;
        logic [RND_W-1:0]          random_draw;
        logic signed [THR_W-1:0]   threshold_word;
    } item_t;

endpackage

`default_nettype wire

[design/lif_if.sv]
`default_nettype none

interface lif_in_if;
    import lif_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [CH_W-1:0]         channel;
    logic [TIME_W-1:0]       sample_time;
    logic signed [SMP_W-1:0] sample;
    logic [RND_W-1:0]        random_draw;
    logic signed [THR_W-1:0] threshold_word;

    modport source
    (
        output valid, command, channel, sample_time, sample, random_draw, threshold_word,
        input  ready
    );

    modport sink
    (
        input  valid, command, channel, sample_time, sample, random_draw, threshold_word,
        output ready
    );
endinterface

interface lif_out_if;
    import lif_pkg::*;

    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   spike_channel;
    logic [TIME_W-1:0] spike_time;

    modport source
    (
        output valid, spike_channel, spike_time,
        input  ready
    );

    modport sink
    (
        input  valid, spike_channel, spike_time,
        output ready
    );
endinterface

`default_nettype wire

[design/leaky_integrate_fire_spike_encoder.sv]
// Leaky integrate-and-fire spike encoder.
// items:  request channel (valid/ready). command selects a sample or a
//         threshold load for one channel; sample_time, sample, random_draw
//         and threshold_word travel with it.
// spikes: result channel (valid/ready) carrying spike_channel, spike_time;
//         zero or one spike per sample request, in request order.
// cfg_wen/cfg_index/cfg_wdata: register writes, index 0 leak_factor,
//         1 sample_weight, 2 refractory_ticks; write only while idle.
// Path: queue, read stage, update stage, then the output register.
// Throughput: one request per cycle unless the output stalls. Same-channel
//         requests in a row: the second waits while the first is in the read
//         stage, set by the read-update loop on the channel state memory.
// Reset: all channel state reads as zero (valid flags, no clearing pass),
//         every channel in stochastic mode with zero gain (no spikes);
//         registers return to no leak, weight 1, no refractory time.
// Stall: while a spike waits on spikes.ready the pipeline holds; a 4-entry
//         queue keeps taking requests until it fills.
`default_nettype none

module leaky_integrate_fire_spike_encoder
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [lif_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lif_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    lif_in_if.sink                          items,
    lif_out_if.source                       spikes
);
    import lif_pkg::*;

    logic [LEAK_W-1:0]  leak_factor_reg;
    logic [WGT_W-1:0]   sample_weight_reg;
    logic [TICKS_W-1:0] refractory_ticks_reg;
    cfg_t               cfg;

    logic               q_full;
    logic               q_push;
    item_t              q_item;
    logic               q_pop;
    logic               q_head_valid;
    item_t              q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leak_factor_reg      <= LEAK_ONE;
            sample_weight_reg    <= WEIGHT_RESET;
            refractory_ticks_reg <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_LEAK_FACTOR:      leak_factor_reg      <= cfg_wdata[LEAK_W-1:0];
                REG_SAMPLE_WEIGHT:    sample_weight_reg    <= cfg_wdata[WGT_W-1:0];
                REG_REFRACTORY_TICKS: refractory_ticks_reg <= cfg_wdata[TICKS_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        cfg.leak_factor      = leak_factor_reg;
        cfg.sample_weight    = sample_weight_reg;
        cfg.refractory_ticks = refractory_ticks_reg;
    end

    lif_front u_front
    (
        .cfg    (cfg),
        .items  (items),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_item)
    );

    lif_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .item_in    (q_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    lif_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .spikes     (spikes)
    );
endmodule

`default_nettype wire

[design/lif_front.sv]
`default_nettype none

module lif_front
(
    input  lif_pkg::cfg_t  cfg,
    lif_in_if.sink         items,
    input  logic           q_full,
    output logic           q_push,
    output lif_pkg::item_t q_item
);
    import lif_pkg::*;

    localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(NUM_CHANNELS);

    logic                      in_range;
    logic signed [WSMP_W:0]    wprod;

    assign items.ready = !q_full;
    assign in_range    = {1'b0, items.channel} < CH_LIMIT;

    // drop requests for channels that do not exist
    assign q_push = items.valid && items.ready && in_range;

    assign wprod = (WSMP_W + 1)'(items.sample) *
                   (WSMP_W + 1)'($signed({1'b0, cfg.sample_weight}));

    always_comb
    begin
        q_item.command        = cmd_t'(items.command);
        q_item.channel        = items.channel;
        q_item.sample_time    = items.sample_time;
        q_item.sample         = items.sample;
        q_item.weighted       = wprod[WSMP_W-1:0];
        q_item.random_draw    = items.random_draw;
        q_item.threshold_word = items.threshold_word;
    end
endmodule

`default_nettype wire

[design/lif_queue.sv]
`default_nettype none
`include "leaky_integrate_fire_spike_encoder_defines.svh"

module lif_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lif_pkg::item_t item_in,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output lif_pkg::item_t head
);
    import lif_pkg::*;

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    `LIF_ASSERT_NEVER(a_queue_overflow, push && full, "request pushed into a full queue")
    `LIF_ASSERT_NEVER(a_queue_underflow, pop && !head_valid, "pop from an empty queue")
    `LIF_ASSERT_NEVER(a_queue_count_bound, count_reg > QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
endmodule

`default_nettype wire

[design/lif_back.sv]
`default_nettype none
`include "leaky_integrate_fire_spike_encoder_defines.svh"

module lif_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  lif_pkg::cfg_t  cfg,
    input  logic           head_valid,
    input  lif_pkg::item_t head,
    output logic           pop,
    lif_out_if.source      spikes
);
    import lif_pkg::*;

    localparam int LPROD_W   = ACC_W + LEAK_W;
    localparam int SUM_W     = ACC_W + 2;
    localparam int ST_PROD_W = SMP_W - 1 + RND_W;

    localparam logic [LPROD_W-1:0] ROUND_HALF = LPROD_W'(1 << (LEAK_FRAC - 1));
    localparam logic [ACC_W-1:0]   ACC_MAX    = {1'b0, {(ACC_W - 1){1'b1}}};
    localparam logic [ACC_W-1:0]   ACC_MIN    = {1'b1, {(ACC_W - 1){1'b0}}};

    typedef struct packed
    {
        logic [ACC_W-1:0]  acc;
        logic [TIME_W-1:0] rend;
    } state_t;

    // channel memories
    state_t                  state_mem [NUM_CHANNELS];
    logic signed [THR_W-1:0] thr_mem   [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] state_vld_reg;
    logic [NUM_CHANNELS-1:0] thr_vld_reg;

    logic                    adv;
    logic                    hazard;
    logic [IDX_W-1:0]        raddr;
    logic [IDX_W-1:0]        waddr;
    logic                    state_we;
    logic                    thr_we;
    state_t                  state_wdata;

    // read stage
    logic                    b1_valid_reg;
    item_t                   b1_reg;
    state_t                  state_raw_reg;
    logic                    state_hit_reg;
    logic                    state_byp_reg;
    state_t                  state_bypdata_reg;
    logic signed [THR_W-1:0] thr_raw_reg;
    logic                    thr_hit_reg;
    logic                    thr_byp_reg;
    logic signed [THR_W-1:0] thr_bypdata_reg;

    state_t                  b1_state;
    logic signed [THR_W-1:0] b1_thr;
    logic                    b1_integrate;
    logic                    b1_active;
    logic                    b1_neg;
    logic [ACC_W-1:0]        b1_mag;
    logic [LEAK_W-1:0]       leak_k;
    logic [LPROD_W-1:0]      leak_prod_next;
    logic [THR_W-1:0]        gain;
    logic                    b1_smp_pos;
    logic [ST_PROD_W-1:0]    st_prod_next;

    // update stage
    logic                    b2_valid_reg;
    item_t                   b2_reg;
    logic                    b2_integrate_reg;
    logic                    b2_active_reg;
    logic                    b2_neg_reg;
    state_t                  b2_state_reg;
    logic signed [THR_W-1:0] b2_thr_reg;
    logic [LPROD_W-1:0]      leak_prod_reg;
    logic                    b2_smp_pos_reg;
    logic                    b2_gain_hi_reg;
    logic [ST_PROD_W-1:0]    st_prod_reg;

    logic [LPROD_W-1:0]      round_sum;
    logic [ACC_W-1:0]        leaked_mag;
    logic signed [SUM_W-1:0] leaked;
    logic signed [SUM_W-1:0] sum;
    logic [ACC_W-1:0]        sat;
    logic signed [ACC_W-1:0] acc_new;
    logic                    fire_int;
    logic                    fire_st;
    logic                    fire;
    logic [TIME_W:0]         end_sum;
    logic [TIME_W-1:0]       end_sat;

    // output register
    logic                    spike_valid_reg;
    logic                    spike_valid_next;
    logic [CH_W-1:0]         spike_ch_reg;
    logic [TIME_W-1:0]       spike_time_reg;

    assign adv    = !spike_valid_reg || spikes.ready;
    assign hazard = b1_valid_reg && (b1_reg.channel == head.channel);
    assign pop    = adv && head_valid && !hazard;
    assign raddr  = head.channel[IDX_W-1:0];
    assign waddr  = b2_reg.channel[IDX_W-1:0];

    // read stage: merge bypass and valid flags, start both multiplies
    always_comb
    begin
        if (state_byp_reg)
        begin
            b1_state = state_bypdata_reg;
        end
        else if (state_hit_reg)
        begin
            b1_state = state_raw_reg;
        end
        else
        begin
            b1_state = '0;
        end

        if (thr_byp_reg)
        begin
            b1_thr = thr_bypdata_reg;
        end
        else if (thr_hit_reg)
        begin
            b1_thr = thr_raw_reg;
        end
        else
        begin
            b1_thr = '0;
        end

        b1_integrate   = !b1_thr[THR_W-1] && (b1_thr != '0);
        b1_active      = b1_reg.sample_time >= b1_state.rend;
        b1_neg         = b1_state.acc[ACC_W-1];
        b1_mag         = b1_neg ? (~b1_state.acc + ACC_W'(1)) : b1_state.acc;
        leak_k         = (cfg.leak_factor > LEAK_ONE) ? LEAK_ONE : cfg.leak_factor;
        leak_prod_next = LPROD_W'(b1_mag) * LPROD_W'(leak_k);
        gain           = ~b1_thr + THR_W'(1);
        b1_smp_pos     = !b1_reg.sample[SMP_W-1] && (b1_reg.sample != '0);
        st_prod_next   = ST_PROD_W'(b1_reg.sample[SMP_W-2:0]) * ST_PROD_W'(gain[RND_W-1:0]);
    end

    // update stage: round the leak, add, saturate, compare
    always_comb
    begin
        round_sum  = leak_prod_reg + ROUND_HALF;
        leaked_mag = round_sum[LEAK_FRAC +: ACC_W];
        leaked     = b2_neg_reg ? -$signed({2'b00, leaked_mag}) : $signed({2'b00, leaked_mag});
        sum        = leaked + $signed({{(SUM_W - WSMP_W){b2_reg.weighted[WSMP_W-1]}},
                                       b2_reg.weighted});

        if (!sum[SUM_W-1] && (sum[SUM_W-2] || sum[SUM_W-3]))
        begin
            sat = ACC_MAX;
        end
        else if (sum[SUM_W-1] && !(sum[SUM_W-2] && sum[SUM_W-3]))
        begin
            sat = ACC_MIN;
        end
        else
        begin
            sat = sum[ACC_W-1:0];
        end

        acc_new  = $signed(b2_active_reg ? sat : b2_state_reg.acc);
        fire_int = acc_new >= b2_thr_reg;
        fire_st  = b2_smp_pos_reg &&
                   (b2_gain_hi_reg || (st_prod_reg > ST_PROD_W'(b2_reg.random_draw)));
        fire     = (b2_reg.command == CMD_SAMPLE) && (b2_integrate_reg ? fire_int : fire_st);

        end_sum = {1'b0, b2_reg.sample_time} + (TIME_W + 1)'(cfg.refractory_ticks);
        end_sat = end_sum[TIME_W] ? {TIME_W{1'b1}} : end_sum[TIME_W-1:0];

        state_wdata.acc  = fire_int ? '0 : acc_new;
        state_wdata.rend = fire_int ? end_sat : b2_state_reg.rend;

        state_we = adv && b2_valid_reg && (b2_reg.command == CMD_SAMPLE) && b2_integrate_reg;
        thr_we   = adv && b2_valid_reg && (b2_reg.command == CMD_LOAD);

        spike_valid_next = b2_valid_reg && fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_vld_reg   <= '0;
            thr_vld_reg     <= '0;
            b1_valid_reg    <= 1'b0;
            b2_valid_reg    <= 1'b0;
            spike_valid_reg <= 1'b0;
            state_hit_reg   <= 1'b0;
            state_byp_reg   <= 1'b0;
            thr_hit_reg     <= 1'b0;
            thr_byp_reg     <= 1'b0;
        end
        else
        begin
            if (state_we)
            begin
                state_vld_reg[waddr] <= 1'b1;
            end
            if (thr_we)
            begin
                thr_vld_reg[waddr] <= 1'b1;
            end
            if (adv)
            begin
                b1_valid_reg    <= pop;
                b2_valid_reg    <= b1_valid_reg;
                spike_valid_reg <= spike_valid_next;
                state_hit_reg   <= state_vld_reg[raddr];
                state_byp_reg   <= state_we && (waddr == raddr);
                thr_hit_reg     <= thr_vld_reg[raddr];
                thr_byp_reg     <= thr_we && (waddr == raddr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_we)
        begin
            state_mem[waddr] <= state_wdata;
        end
        if (thr_we)
        begin
            thr_mem[waddr] <= b2_reg.threshold_word;
        end
        if (adv)
        begin
            state_raw_reg     <= state_mem[raddr];
            state_bypdata_reg <= state_wdata;
            thr_raw_reg       <= thr_mem[raddr];
            thr_bypdata_reg   <= b2_reg.threshold_word;
            b1_reg            <= head;

            b2_reg           <= b1_reg;
            b2_integrate_reg <= b1_integrate;
            b2_active_reg    <= b1_active;
            b2_neg_reg       <= b1_neg;
            b2_state_reg     <= b1_state;
            b2_thr_reg       <= b1_thr;
            leak_prod_reg    <= leak_prod_next;
            b2_smp_pos_reg   <= b1_smp_pos;
            b2_gain_hi_reg   <= |gain[THR_W-1:RND_W];
            st_prod_reg      <= st_prod_next;

            spike_ch_reg   <= b2_reg.channel;
            spike_time_reg <= b2_reg.sample_time;
        end
    end

    assign spikes.valid         = spike_valid_reg;
    assign spikes.spike_channel = spike_ch_reg;
    assign spikes.spike_time    = spike_time_reg;

    `LIF_ASSERT_NEVER(a_stages_distinct_channel,
        b1_valid_reg && b2_valid_reg && (b1_reg.channel == b2_reg.channel),
        "read and update stages hold the same channel")
    `LIF_ASSERT_IMPLY(a_spike_from_update,
        spike_valid_reg && !$past(spike_valid_reg), $past(b2_valid_reg),
        "spike appeared without an item in the update stage")
    `LIF_ASSERT_NEVER(a_single_store_write, state_we && thr_we,
        "threshold and channel state written by one request")
endmodule

`default_nettype wire
